// ===== hdl/dspr_pkg.sv =====
`default_nettype none
package dspr_pkg;

	localparam int COORD_WIDTH_DEF = 12;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int MAX_RUNS = 4;
	localparam int RUN_IDX_W = $clog2(MAX_RUNS);
	localparam int RUN_CNT_W = $clog2(MAX_RUNS + 1);
	localparam int CODE_W = 8;
	localparam int LEN_W = 9;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} run_desc_t;

	typedef struct packed {
		run_desc_t [MAX_RUNS-1:0] runs;
		logic [RUN_CNT_W-1:0]     count;
		logic                     fs;
		logic                     bottom;
		logic                     eol;
	} queue_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage
`default_nettype wire

// ===== hdl/dspr_byte_if.sv =====
`default_nettype none
interface dspr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       field_start;
	logic       bottom_field;

	modport source (output valid, output data_byte, output field_start, output bottom_field,
		input ready);
	modport sink (input valid, input data_byte, input field_start, input bottom_field,
		output ready);
endinterface
`default_nettype wire

// ===== hdl/dspr_run_if.sv =====
`default_nettype none
interface dspr_run_if #(
	parameter int COORD_WIDTH = dspr_pkg::COORD_WIDTH_DEF
);
	logic                   valid;
	logic                   ready;
	logic [7:0]             pixel_code;
	logic [8:0]             run_length;
	logic [COORD_WIDTH-1:0] column;
	logic [COORD_WIDTH-1:0] row;
	logic                   last;

	modport source (output valid, output pixel_code, output run_length, output column,
		output row, output last, input ready);
	modport sink (input valid, input pixel_code, input run_length, input column,
		input row, input last, output ready);
endinterface
`default_nettype wire

// ===== hdl/dspr_front.sv =====
`default_nettype none
module dspr_front (
	input  logic                   clk,
	input  logic                   arst_n,
	dspr_byte_if.sink              bytes,
	input  dspr_pkg::queue_status_t q_stat,
	output logic                   push,
	output dspr_pkg::queue_entry_t entry
);

	localparam logic [2:0] MODE_TYPE  = 3'd0;
	localparam logic [2:0] MODE_SKIP  = 3'd1;
	localparam logic [2:0] MODE_TWO   = 3'd2;
	localparam logic [2:0] MODE_FOUR  = 3'd3;
	localparam logic [2:0] MODE_EIGHT = 3'd4;

	localparam logic [2:0] PH_CODE    = 3'd0;
	localparam logic [2:0] PH_S1      = 3'd1;
	localparam logic [2:0] PH_S2      = 3'd2;
	localparam logic [2:0] PH_SW      = 3'd3;
	localparam logic [2:0] PH_LEN     = 3'd4;
	localparam logic [2:0] PH_RUNCODE = 3'd5;
	localparam logic [2:0] PH_ZLEN    = 3'd6;

	localparam logic [7:0] DT_TWO   = 8'h10;
	localparam logic [7:0] DT_FOUR  = 8'h11;
	localparam logic [7:0] DT_EIGHT = 8'h12;
	localparam logic [7:0] DT_MAP2  = 8'h20;
	localparam logic [7:0] DT_MAP4  = 8'h21;
	localparam logic [7:0] DT_MAP16 = 8'h22;
	localparam logic [7:0] DT_EOL   = 8'hF0;

	typedef struct packed {
		logic [2:0] mode;
		logic [2:0] phase;
		logic [4:0] skip;
		logic [7:0] acc;
		logic [3:0] wanted;
		logic [4:0] pend_base;
		logic [7:0] pend_ext;
	} parse_state_t;

	localparam parse_state_t PARSE_INIT = '{mode: MODE_TYPE, default: '0};

	function automatic parse_state_t want(parse_state_t s, logic [2:0] ph, logic [3:0] nb);
		parse_state_t r;
		r = s;
		r.phase = ph;
		r.wanted = nb;
		r.acc = '0;
		return r;
	endfunction

	parse_state_t state_q;
	parse_state_t st;
	logic [3:0] cw;
	logic [7:0] v;
	logic done;
	logic eol;
	logic accept;
	logic [dspr_pkg::RUN_CNT_W-1:0] n;
	logic [dspr_pkg::CODE_W-1:0] code_r [dspr_pkg::MAX_RUNS];
	logic [4:0] base_r [dspr_pkg::MAX_RUNS];
	logic [7:0] ext_r [dspr_pkg::MAX_RUNS];

	assign bytes.ready = !q_stat.full;
	assign accept = bytes.valid && bytes.ready;

	always_comb begin
		st = state_q;
		n = '0;
		done = 1'b0;
		eol = 1'b0;
		v = '0;
		for (int k = 0; k < dspr_pkg::MAX_RUNS; k++) begin
			code_r[k] = '0;
			base_r[k] = '0;
			ext_r[k] = '0;
		end
		if (bytes.field_start) begin
			st = PARSE_INIT;
		end
		cw = (st.mode == MODE_TWO) ? 4'd2 : ((st.mode == MODE_FOUR) ? 4'd4 : 4'd8);
		unique case (st.mode) inside
			MODE_SKIP: begin
				if (st.skip != 5'd0) begin
					st.skip = st.skip - 5'd1;
				end
				if (st.skip == 5'd0) begin
					st.mode = MODE_TYPE;
				end
			end
			MODE_TWO, MODE_FOUR, MODE_EIGHT: begin
				for (int i = 7; i >= 0; i--) begin
					if (!done) begin
						st.acc = {st.acc[6:0], bytes.data_byte[3'(i)]};
						if (st.wanted > 4'd1) begin
							st.wanted = st.wanted - 4'd1;
						end else begin
							v = st.acc;
							unique case (st.phase)
								PH_CODE: begin
									if (v != 8'd0) begin
										code_r[n[dspr_pkg::RUN_IDX_W-1:0]] = v;
										base_r[n[dspr_pkg::RUN_IDX_W-1:0]] = 5'd1;
										n = n + 1'b1;
										st = want(st, PH_CODE, cw);
									end else begin
										st = want(st, PH_S1, 4'd1);
									end
								end
								PH_S1: begin
									if (st.mode == MODE_TWO) begin
										if (v[0]) begin
											st.pend_base = 5'd3;
											st = want(st, PH_LEN, 4'd3);
										end else begin
											st = want(st, PH_S2, 4'd1);
										end
									end else if (st.mode == MODE_FOUR) begin
										if (v[0]) begin
											st = want(st, PH_S2, 4'd1);
										end else begin
											st = want(st, PH_ZLEN, 4'd3);
										end
									end else begin
										if (v[0]) begin
											st.pend_base = 5'd3;
											st = want(st, PH_LEN, 4'd7);
										end else begin
											st = want(st, PH_ZLEN, 4'd7);
										end
									end
								end
								PH_S2: begin
									if (st.mode == MODE_TWO) begin
										if (v[0]) begin
											base_r[n[dspr_pkg::RUN_IDX_W-1:0]] = 5'd1;
											n = n + 1'b1;
											st = want(st, PH_CODE, cw);
										end else begin
											st = want(st, PH_SW, 4'd2);
										end
									end else begin
										if (v[0]) begin
											st = want(st, PH_SW, 4'd2);
										end else begin
											st.pend_base = 5'd4;
											st = want(st, PH_LEN, 4'd2);
										end
									end
								end
								PH_SW: begin
									case (v[1:0])
										2'd0: begin
											if (st.mode == MODE_TWO) begin
												done = 1'b1;
											end else begin
												base_r[n[dspr_pkg::RUN_IDX_W-1:0]] = 5'd1;
												n = n + 1'b1;
												st = want(st, PH_CODE, cw);
											end
										end
										2'd1: begin
											base_r[n[dspr_pkg::RUN_IDX_W-1:0]] = 5'd2;
											n = n + 1'b1;
											st = want(st, PH_CODE, cw);
										end
										2'd2: begin
											st.pend_base = (st.mode == MODE_TWO) ? 5'd12 : 5'd9;
											st = want(st, PH_LEN, 4'd4);
										end
										default: begin
											st.pend_base = (st.mode == MODE_TWO) ? 5'd29 : 5'd25;
											st = want(st, PH_LEN, 4'd8);
										end
									endcase
								end
								PH_LEN: begin
									st.pend_ext = v;
									st = want(st, PH_RUNCODE, cw);
								end
								PH_RUNCODE: begin
									code_r[n[dspr_pkg::RUN_IDX_W-1:0]] = v;
									base_r[n[dspr_pkg::RUN_IDX_W-1:0]] = st.pend_base;
									ext_r[n[dspr_pkg::RUN_IDX_W-1:0]] = st.pend_ext;
									n = n + 1'b1;
									st = want(st, PH_CODE, cw);
								end
								PH_ZLEN: begin
									if (v == 8'd0) begin
										done = 1'b1;
									end else begin
										base_r[n[dspr_pkg::RUN_IDX_W-1:0]] =
											(st.mode == MODE_FOUR) ? 5'd2 : 5'd0;
										ext_r[n[dspr_pkg::RUN_IDX_W-1:0]] = v;
										n = n + 1'b1;
										st = want(st, PH_CODE, cw);
									end
								end
								default: begin
									st = want(st, PH_CODE, cw);
								end
							endcase
							if (done) begin
								st.mode = MODE_TYPE;
								st = want(st, PH_CODE, 4'd0);
							end
						end
					end
				end
			end
			default: begin
				st.mode = MODE_TYPE;
				unique case (bytes.data_byte)
					DT_TWO: begin
						st.mode = MODE_TWO;
						st = want(st, PH_CODE, 4'd2);
					end
					DT_FOUR: begin
						st.mode = MODE_FOUR;
						st = want(st, PH_CODE, 4'd4);
					end
					DT_EIGHT: begin
						st.mode = MODE_EIGHT;
						st = want(st, PH_CODE, 4'd8);
					end
					DT_MAP2: begin
						st.mode = MODE_SKIP;
						st.skip = 5'd2;
					end
					DT_MAP4: begin
						st.mode = MODE_SKIP;
						st.skip = 5'd4;
					end
					DT_MAP16: begin
						st.mode = MODE_SKIP;
						st.skip = 5'd16;
					end
					DT_EOL: begin
						eol = 1'b1;
					end
					default: begin
					end
				endcase
			end
		endcase
	end

	always_comb begin
		for (int k = 0; k < dspr_pkg::MAX_RUNS; k++) begin
			entry.runs[k].code = code_r[k];
			entry.runs[k].len = dspr_pkg::LEN_W'(base_r[k]) + dspr_pkg::LEN_W'(ext_r[k]);
		end
		entry.count = n;
		entry.fs = bytes.field_start;
		entry.bottom = bytes.bottom_field;
		entry.eol = eol;
	end

	// bytes that leave coordinates and output untouched never reach the queue
	assign push = accept && ((n != '0) || bytes.field_start || eol);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PARSE_INIT;
		end else if (accept) begin
			state_q <= st;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/dspr_queue.sv =====
`default_nettype none
module dspr_queue #(
	parameter int DEPTH = dspr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  dspr_pkg::queue_entry_t  entry,
	input  logic                    pop,
	output dspr_pkg::queue_entry_t  head,
	output dspr_pkg::queue_status_t status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	dspr_pkg::queue_entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign head = mem_q[rd_ptr_q];
	assign status.full = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/dspr_back.sv =====
`default_nettype none
module dspr_back #(
	parameter int COORD_WIDTH = dspr_pkg::COORD_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dspr_pkg::queue_entry_t  head,
	input  dspr_pkg::queue_status_t q_stat,
	output logic                    pop,
	dspr_run_if.source              runs
);

	localparam int SW = ((COORD_WIDTH > dspr_pkg::LEN_W) ? COORD_WIDTH : dspr_pkg::LEN_W) + 1;
	localparam logic [COORD_WIDTH-1:0] CMAX = {COORD_WIDTH{1'b1}};

	logic                            valid_q;
	logic [dspr_pkg::CODE_W-1:0]     code_q;
	logic [dspr_pkg::LEN_W-1:0]      len_q;
	logic [COORD_WIDTH-1:0]          col_out_q;
	logic [COORD_WIDTH-1:0]          row_out_q;
	logic                            last_q;
	logic [COORD_WIDTH-1:0]          col_q;
	logic [COORD_WIDTH-1:0]          row_q;
	logic [dspr_pkg::RUN_IDX_W-1:0]  idx_q;

	dspr_pkg::run_desc_t run;
	logic out_free;
	logic coord_only;
	logic emit;
	logic is_last;
	logic [SW-1:0] col_sum;
	logic [COORD_WIDTH-1:0] col_next;
	logic [COORD_WIDTH-1:0] row_base;
	logic [SW-1:0] row_sum;
	logic [COORD_WIDTH-1:0] row_next;

	assign run = head.runs[idx_q];
	assign out_free = !valid_q || runs.ready;
	assign coord_only = !q_stat.empty && (head.count == '0);
	assign emit = !q_stat.empty && (head.count != '0) && out_free;
	assign is_last = (dspr_pkg::RUN_CNT_W'(idx_q) + 1'b1) == head.count;
	assign pop = coord_only || (emit && is_last);

	assign col_sum = SW'(col_q) + SW'(run.len);
	assign col_next = (col_sum > SW'(CMAX)) ? CMAX : col_sum[COORD_WIDTH-1:0];

	// field start and end of line both restart the column
	assign row_base = head.fs ? COORD_WIDTH'(head.bottom) : row_q;
	assign row_sum = SW'(row_base) + SW'(2);
	assign row_next = head.eol ?
		((row_sum > SW'(CMAX)) ? CMAX : row_sum[COORD_WIDTH-1:0]) : row_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			col_q <= '0;
			row_q <= '0;
			idx_q <= '0;
		end else begin
			if (emit) begin
				valid_q <= 1'b1;
				col_q <= col_next;
				idx_q <= is_last ? '0 : idx_q + 1'b1;
			end else if (runs.ready) begin
				valid_q <= 1'b0;
			end
			if (coord_only) begin
				col_q <= '0;
				row_q <= row_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			code_q <= run.code;
			len_q <= run.len;
			col_out_q <= col_q;
			row_out_q <= row_q;
			last_q <= is_last;
		end
	end

	assign runs.valid = valid_q;
	assign runs.pixel_code = code_q;
	assign runs.run_length = len_q;
	assign runs.column = col_out_q;
	assign runs.row = row_out_q;
	assign runs.last = last_q;

endmodule
`default_nettype wire

// ===== hdl/dvb_subtitle_pixel_run_decoder.sv =====
`default_nettype none
// Decodes the pixel-data byte stream of a subtitle object field into pixel runs (code, length,
// first column, row, last-of-byte). The parser takes one byte per cycle whenever its small run
// queue has room; a byte of code string yields up to four runs, which leave through a registered
// output one run per cycle while the receiver is ready, and bytes yielding no run and no
// coordinate change go no further than the parser.
// Map tables are skipped and not applied; codes come out as they appear in the stream.
module dvb_subtitle_pixel_run_decoder #(
	parameter int COORD_WIDTH = dspr_pkg::COORD_WIDTH_DEF,
	parameter int QUEUE_DEPTH = dspr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	dspr_byte_if.sink  bytes,
	dspr_run_if.source runs
);

	dspr_pkg::queue_entry_t  entry;
	dspr_pkg::queue_entry_t  head;
	dspr_pkg::queue_status_t q_stat;
	logic push;
	logic pop;

	dspr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.q_stat (q_stat),
		.push   (push),
		.entry  (entry)
	);

	dspr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.entry  (entry),
		.pop    (pop),
		.head   (head),
		.status (q_stat)
	);

	dspr_back #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.runs   (runs)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_stat.empty))
		else $error("pop from empty queue");

	a_fs_no_runs: assert property (@(posedge clk) disable iff (!arst_n)
		push && entry.fs |-> entry.count == '0)
		else $error("field start byte produced runs");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		runs.valid |-> runs.run_length != '0)
		else $error("zero length run");

endmodule
`default_nettype wire
